### src/i2cram_pkg.sv
package i2cram_pkg;

  localparam int PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_IDLE       = 4'd0;
  localparam logic [PhaseW-1:0] PH_START_HIGH = 4'd1;
  localparam logic [PhaseW-1:0] PH_START_FALL = 4'd2;
  localparam logic [PhaseW-1:0] PH_RS_LOW     = 4'd3;
  localparam logic [PhaseW-1:0] PH_TX_LOW     = 4'd4;
  localparam logic [PhaseW-1:0] PH_TX_HIGH    = 4'd5;
  localparam logic [PhaseW-1:0] PH_TACK_LOW   = 4'd6;
  localparam logic [PhaseW-1:0] PH_TACK_HIGH  = 4'd7;
  localparam logic [PhaseW-1:0] PH_RX_LOW     = 4'd8;
  localparam logic [PhaseW-1:0] PH_RX_HIGH    = 4'd9;
  localparam logic [PhaseW-1:0] PH_MACK_LOW   = 4'd10;
  localparam logic [PhaseW-1:0] PH_MACK_HIGH  = 4'd11;
  localparam logic [PhaseW-1:0] PH_STOP_LOW   = 4'd12;
  localparam logic [PhaseW-1:0] PH_STOP_HIGH  = 4'd13;
  localparam logic [PhaseW-1:0] PH_STOP_END   = 4'd14;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [6:0] DEV_ADDR_RST    = 7'd42;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd10;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  register_index;
    logic [15:0] write_word;
    logic        sda_level;
  } req_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_drive;
    logic        sda_output_enable;
    logic        busy_res;
    logic        done_res;
    logic        ack_error;
    logic [15:0] read_word;
  } res_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [2:0]        bit_cnt;
    logic [2:0]        byte_cnt;
    logic [7:0]        shift;
    logic [7:0]        wait_cnt;
    logic              rd;
    logic [7:0]        reg_idx;
    logic [15:0]       wdata;
    logic [15:0]       recv;
    logic              err;
  } st_t;

endpackage

### src/i2cram_if.sv
interface i2cram_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  register_index;
  logic [15:0] write_word;
  logic        sda_level;

  modport source (output valid, opcode, register_index, write_word, sda_level,
                  input ready);
  modport sink (input valid, opcode, register_index, write_word, sda_level,
                output ready);
endinterface

interface i2cram_out_if;
  logic        valid;
  logic        ready;
  logic        scl_level;
  logic        sda_drive;
  logic        sda_output_enable;
  logic        busy_res;
  logic        done_res;
  logic        ack_error;
  logic [15:0] read_word;

  modport source (output valid, scl_level, sda_drive, sda_output_enable, busy_res,
                  done_res, ack_error, read_word, input ready);
  modport sink (input valid, scl_level, sda_drive, sda_output_enable, busy_res,
                done_res, ack_error, read_word, output ready);
endinterface

### src/i2c_register_access_master.sv
// Channel  Dir  Handshake      Word
// in_ch    in   valid/ready    opcode, register_index, write_word, sda_level
// out_ch   out  valid/ready    scl_level, sda_drive, sda_output_enable, busy_res,
//                              done_res, ack_error, read_word
// cfg      in   cfg_we only    cfg_index selects address or ack timeout
//
// Each input word is one half-bit tick and yields one output word.
// A word passes an input register, then the bus sequencer updates its state and
// the output register together, so one word is taken every cycle unless out_ch stalls.
// An accepted word is held in the input register, then its output word is registered.
// Reset is synchronous; a stalled output holds the input register, then in_ch.ready.
module i2c_register_access_master
  import i2cram_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  i2cram_in_if.sink         in_ch,
  i2cram_out_if.source      out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);

  logic       in_v_r;
  req_t       in_word_r;
  logic       out_v_r;
  res_t       out_word_r;
  st_t        st_r;
  st_t        st_nxt;
  res_t       res_nxt;
  logic [6:0] dev_addr_r;
  logic [7:0] ack_to_r;
  logic       adv;

  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  i2cram_step u_step (
    .cur         (st_r),
    .req         (in_word_r),
    .dev_addr    (dev_addr_r),
    .ack_timeout (ack_to_r),
    .nxt         (st_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      ack_to_r   <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEV_ADDR) begin
        dev_addr_r <= cfg_data[6:0];
      end else begin
        ack_to_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_word_r.opcode         <= in_ch.opcode;
      in_word_r.register_index <= in_ch.register_index;
      in_word_r.write_word     <= in_ch.write_word;
      in_word_r.sda_level      <= in_ch.sda_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      st_r    <= '0;
    end else begin
      if (adv) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.scl_level         = out_word_r.scl_level;
  assign out_ch.sda_drive         = out_word_r.sda_drive;
  assign out_ch.sda_output_enable = out_word_r.sda_output_enable;
  assign out_ch.busy_res          = out_word_r.busy_res;
  assign out_ch.done_res          = out_word_r.done_res;
  assign out_ch.ack_error         = out_word_r.ack_error;
  assign out_ch.read_word         = out_word_r.read_word;

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.done_res |=> st_r.phase == PH_IDLE)
    else $error("finished transaction did not return to idle");

  a_err_sets_stop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.err) |-> st_r.phase == PH_STOP_LOW)
    else $error("ack error raised outside a stop");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_word_r))
    else $error("pending input word lost while output stalled");

endmodule

### src/i2cram_step.sv
module i2cram_step
  import i2cram_pkg::*;
(
  input  st_t        cur,
  input  req_t       req,
  input  logic [6:0] dev_addr,
  input  logic [7:0] ack_timeout,
  output st_t        nxt,
  output res_t       res
);

  function automatic logic [7:0] tx_byte(input logic [2:0] k, input logic [6:0] addr,
                                         input st_t s);
    logic [7:0] r;
    begin
      case (k)
        3'd0:    r = {addr, 1'b0};
        3'd1:    r = s.reg_idx;
        3'd2:    r = s.rd ? {addr, 1'b1} : s.wdata[15:8];
        3'd3:    r = s.wdata[7:0];
        default: r = 8'hFF;
      endcase
      return r;
    end
  endfunction

  logic       scl, drv, oe, busy, done;
  logic       ack_go, missing, tx_go;
  logic [7:0] rx_byte;

  always_comb begin
    nxt     = cur;
    scl     = 1'b1;
    drv     = 1'b1;
    oe      = 1'b1;
    busy    = 1'b1;
    done    = 1'b0;
    tx_go   = 1'b0;
    ack_go  = 1'b0;
    missing = 1'b0;
    rx_byte = {cur.shift[6:0], req.sda_level};

    if (nxt.phase == 4'd15) begin
      nxt.phase = PH_IDLE;
    end
    if (nxt.phase == PH_IDLE && (req.opcode == OP_WRITE || req.opcode == OP_READ)) begin
      nxt.rd       = (req.opcode == OP_READ);
      nxt.reg_idx  = req.register_index;
      nxt.wdata    = req.write_word;
      nxt.err      = 1'b0;
      nxt.byte_cnt = 3'd0;
      nxt.bit_cnt  = 3'd0;
      nxt.wait_cnt = 8'd0;
      nxt.phase    = PH_START_HIGH;
    end

    unique case (nxt.phase)
      PH_IDLE: begin
        busy = 1'b0;
      end
      PH_START_HIGH: begin
        nxt.phase = PH_START_FALL;
      end
      PH_START_FALL: begin
        drv   = 1'b0;
        tx_go = 1'b1;
      end
      PH_RS_LOW: begin
        scl       = 1'b0;
        nxt.phase = PH_START_HIGH;
      end
      PH_TX_LOW: begin
        scl       = 1'b0;
        drv       = cur.shift[7];
        nxt.phase = PH_TX_HIGH;
      end
      PH_TX_HIGH: begin
        drv       = cur.shift[7];
        nxt.shift = {cur.shift[6:0], 1'b0};
        if (cur.bit_cnt == 3'd7) begin
          nxt.bit_cnt  = 3'd0;
          nxt.wait_cnt = 8'd0;
          nxt.phase    = PH_TACK_LOW;
        end else begin
          nxt.bit_cnt = cur.bit_cnt + 3'd1;
          nxt.phase   = PH_TX_LOW;
        end
      end
      PH_TACK_LOW: begin
        scl       = 1'b0;
        oe        = 1'b0;
        nxt.phase = PH_TACK_HIGH;
      end
      PH_TACK_HIGH: begin
        oe = 1'b0;
        if (!req.sda_level) begin
          ack_go = 1'b1;
        end else if (cur.wait_cnt >= ack_timeout) begin
          ack_go  = 1'b1;
          missing = 1'b1;
        end else begin
          nxt.wait_cnt = cur.wait_cnt + 8'd1;
        end
      end
      PH_RX_LOW: begin
        scl       = 1'b0;
        oe        = 1'b0;
        nxt.phase = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        oe        = 1'b0;
        nxt.shift = rx_byte;
        if (cur.bit_cnt == 3'd7) begin
          nxt.bit_cnt = 3'd0;
          if (cur.byte_cnt == 3'd3) begin
            nxt.recv[15:8] = rx_byte;
          end else begin
            nxt.recv[7:0] = rx_byte;
          end
          nxt.phase = PH_MACK_LOW;
        end else begin
          nxt.bit_cnt = cur.bit_cnt + 3'd1;
          nxt.phase   = PH_RX_LOW;
        end
      end
      PH_MACK_LOW: begin
        scl       = 1'b0;
        drv       = (cur.byte_cnt != 3'd3);
        nxt.phase = PH_MACK_HIGH;
      end
      PH_MACK_HIGH: begin
        drv = (cur.byte_cnt != 3'd3);
        if (cur.byte_cnt == 3'd3) begin
          nxt.byte_cnt = 3'd4;
          nxt.shift    = 8'd0;
          nxt.bit_cnt  = 3'd0;
          nxt.phase    = PH_RX_LOW;
        end else begin
          nxt.phase = PH_STOP_LOW;
        end
      end
      PH_STOP_LOW: begin
        scl       = 1'b0;
        drv       = 1'b0;
        nxt.phase = PH_STOP_HIGH;
      end
      PH_STOP_HIGH: begin
        drv       = 1'b0;
        nxt.phase = PH_STOP_END;
      end
      PH_STOP_END: begin
        busy      = 1'b0;
        done      = 1'b1;
        nxt.phase = PH_IDLE;
      end
      default: begin
        busy      = 1'b0;
        nxt.phase = PH_IDLE;
      end
    endcase

    if (ack_go) begin
      if (!cur.rd) begin
        if (missing && cur.byte_cnt != 3'd1) begin
          nxt.err   = 1'b1;
          nxt.phase = PH_STOP_LOW;
        end else if (cur.byte_cnt >= 3'd3) begin
          nxt.phase = PH_STOP_LOW;
        end else begin
          nxt.byte_cnt = cur.byte_cnt + 3'd1;
          tx_go        = 1'b1;
        end
      end else if (cur.byte_cnt == 3'd0) begin
        nxt.byte_cnt = 3'd1;
        tx_go        = 1'b1;
      end else if (cur.byte_cnt == 3'd1) begin
        nxt.byte_cnt = 3'd2;
        nxt.phase    = PH_RS_LOW;
      end else begin
        nxt.byte_cnt = 3'd3;
        nxt.shift    = 8'd0;
        nxt.bit_cnt  = 3'd0;
        nxt.phase    = PH_RX_LOW;
      end
    end

    if (tx_go) begin
      nxt.shift   = tx_byte(nxt.byte_cnt, dev_addr, nxt);
      nxt.bit_cnt = 3'd0;
      nxt.phase   = PH_TX_LOW;
    end

    res.scl_level         = scl;
    res.sda_drive         = drv;
    res.sda_output_enable = oe;
    res.busy_res          = busy;
    res.done_res          = done;
    res.ack_error         = nxt.err;
    res.read_word         = nxt.recv;
  end

endmodule
